// ===== sv/pmr_pkg.sv =====
// ----------------------------------------------------------------------------
// pmr_pkg - shared types and constants for the pll m/n ratio solver
// holds widths, microcode encoding, the control store and status codes
// ----------------------------------------------------------------------------
package pmr_pkg;

  localparam int HZ_BITS   = 32;
  localparam int DATA_BITS = 13;  // whole MHz values of a 32-bit Hz count
  localparam int CW_BITS   = 14;
  localparam int CNT_BITS  = $clog2(DATA_BITS + 1);

  localparam int DEFAULT_DIVIDER_BITS    = 5;
  localparam int DEFAULT_MULTIPLIER_BITS = 9;

  localparam logic [HZ_BITS-1:0] HZ_PER_MHZ = 32'd1000000;

  // floor(2^42 / 1e6): the estimate x*RECIP >> 42 is the quotient or one less
  localparam int                 RECIP_SHIFT = 42;
  localparam int                 RECIP_BITS  = 23;
  localparam logic [RECIP_BITS-1:0] RECIP    = 23'd4398046;
  localparam int                 PROD_BITS   = HZ_BITS + RECIP_BITS;

  // register map
  localparam int ADDR_BITS = 4;
  localparam logic [1:0] REG_BASE_CLOCK = 2'd0;
  localparam logic [1:0] REG_VCO_LOW    = 2'd1;
  localparam logic [1:0] REG_VCO_HIGH   = 2'd2;

  localparam logic [HZ_BITS-1:0] RESET_BASE_CLOCK = 32'd24000000;
  localparam logic [HZ_BITS-1:0] RESET_VCO_LOW    = 32'd700000000;
  localparam logic [HZ_BITS-1:0] RESET_VCO_HIGH   = 32'd1300000000;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_N_BIG    = 2'd1;
  localparam logic [1:0] STATUS_M_BIG    = 2'd2;
  localparam logic [1:0] STATUS_NO_RATIO = 2'd3;

  typedef struct packed {
    logic [HZ_BITS-1:0] base_clock_hz;
    logic [HZ_BITS-1:0] vco_low_hz;
    logic [HZ_BITS-1:0] vco_high_hz;
  } cfg_t;

  // microcode
  localparam int PC_BITS = 4;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_MUL_REF,
    OP_CORR_REF,
    OP_MUL_TGT,
    OP_CORR_TGT,
    OP_GCD_INIT,
    OP_GCD_STEP,
    OP_GCD_DONE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FINISH,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_REQ,
    C_GCD_BUSY,
    C_G_ZERO,
    C_DIV_BUSY,
    C_OUT_BLOCKED,
    C_ALWAYS
  } cond_t;

  typedef struct packed {
    op_t                op;
    cond_t              cond;
    logic [PC_BITS-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic req_fire;
    logic gcd_busy;
    logic g_zero;
    logic div_busy;
    logic out_blocked;
  } flags_t;

  localparam logic [PC_BITS-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_BITS-1:0] PC_MUL_REF  = 4'd1;
  localparam logic [PC_BITS-1:0] PC_CORR_REF = 4'd2;
  localparam logic [PC_BITS-1:0] PC_MUL_TGT  = 4'd3;
  localparam logic [PC_BITS-1:0] PC_CORR_TGT = 4'd4;
  localparam logic [PC_BITS-1:0] PC_GCD_INIT = 4'd5;
  localparam logic [PC_BITS-1:0] PC_GCD_STEP = 4'd6;
  localparam logic [PC_BITS-1:0] PC_GCD_DONE = 4'd7;
  localparam logic [PC_BITS-1:0] PC_DIV_INIT = 4'd8;
  localparam logic [PC_BITS-1:0] PC_DIV_STEP = 4'd9;
  localparam logic [PC_BITS-1:0] PC_FINISH   = 4'd10;
  localparam logic [PC_BITS-1:0] PC_RETURN   = 4'd11;

  // control store: a true condition jumps to target, else fall through
  function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: PC_IDLE};
    unique case (pc)
      PC_IDLE:     w = '{op: OP_IDLE,     cond: C_NO_REQ,      target: PC_IDLE};
      PC_MUL_REF:  w = '{op: OP_MUL_REF,  cond: C_NEVER,       target: PC_IDLE};
      PC_CORR_REF: w = '{op: OP_CORR_REF, cond: C_NEVER,       target: PC_IDLE};
      PC_MUL_TGT:  w = '{op: OP_MUL_TGT,  cond: C_NEVER,       target: PC_IDLE};
      PC_CORR_TGT: w = '{op: OP_CORR_TGT, cond: C_NEVER,       target: PC_IDLE};
      PC_GCD_INIT: w = '{op: OP_GCD_INIT, cond: C_NEVER,       target: PC_IDLE};
      PC_GCD_STEP: w = '{op: OP_GCD_STEP, cond: C_GCD_BUSY,    target: PC_GCD_STEP};
      PC_GCD_DONE: w = '{op: OP_GCD_DONE, cond: C_NEVER,       target: PC_IDLE};
      PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_G_ZERO,      target: PC_FINISH};
      PC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_BUSY,    target: PC_DIV_STEP};
      PC_FINISH:   w = '{op: OP_FINISH,   cond: C_OUT_BLOCKED, target: PC_FINISH};
      PC_RETURN:   w = '{op: OP_NOP,      cond: C_ALWAYS,      target: PC_IDLE};
      default:     w = '{op: OP_NOP,      cond: C_ALWAYS,      target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/pmr_req_if.sv =====
// ----------------------------------------------------------------------------
// pmr_req_if - request channel
// valid/ready channel carrying reference and target frequencies in Hz
// ----------------------------------------------------------------------------
interface pmr_req_if;
  logic                        valid;
  logic                        ready;
  logic [pmr_pkg::HZ_BITS-1:0] reference_hz;
  logic [pmr_pkg::HZ_BITS-1:0] target_hz;

  modport source (output valid, reference_hz, target_hz, input ready);
  modport sink   (input valid, reference_hz, target_hz, output ready);
endinterface

// ===== sv/pmr_res_if.sv =====
// ----------------------------------------------------------------------------
// pmr_res_if - result channel
// valid/ready channel carrying the solved divider, multiplier and status
// ----------------------------------------------------------------------------
interface pmr_res_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [pmr_pkg::DATA_BITS-1:0] divider_n;
  logic [pmr_pkg::DATA_BITS-1:0] multiplier_m;
  logic [pmr_pkg::CW_BITS-1:0]   control_word;
  logic                          vco_out_of_range;

  modport source (output valid, status, divider_n, multiplier_m, control_word,
                  vco_out_of_range, input ready);
  modport sink   (input valid, status, divider_n, multiplier_m, control_word,
                  vco_out_of_range, output ready);
endinterface

// ===== sv/pll_mn_ratio_solver.sv =====
// ----------------------------------------------------------------------------
// pll_mn_ratio_solver - pll divider/multiplier solver
// reduces target/reference MHz ratio by its gcd into pll n and m settings
// ----------------------------------------------------------------------------
// from request transaction to result valid: mhz conversion of both values, the
//   gcd steps, then the division, which is skipped when both MHz values are zero,
//   plus any wait on a held result; one request in flight, and the idle step
//   takes the next while a result is held
// reset: rst is synchronous, active high; holds request ready low, clears the
//   step counter and result valid, loads base clock 24 MHz, vco 700/1300 MHz
module pll_mn_ratio_solver #(
  parameter int DIVIDER_BITS    = pmr_pkg::DEFAULT_DIVIDER_BITS,
  parameter int MULTIPLIER_BITS = pmr_pkg::DEFAULT_MULTIPLIER_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  pmr_req_if.sink                       req,
  pmr_res_if.source                     res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [pmr_pkg::HZ_BITS-1:0]   pwdata,
  output logic [pmr_pkg::HZ_BITS-1:0]   prdata,
  output logic                          pready
);
  import pmr_pkg::*;

  // register file shared by every request
  cfg_t   cfg;
  // current control word and the flags its jump conditions look at
  ucode_t ctl;
  flags_t flags;

  pmr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // program: capture, hz->mhz for both values, gcd loop, divide, deliver
  pmr_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  // datapath takes one transaction in its idle step and holds the result
  // in an output register until the sink takes it
  pmr_datapath #(
    .DIVIDER_BITS    (DIVIDER_BITS),
    .MULTIPLIER_BITS (MULTIPLIER_BITS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .cfg   (cfg),
    .flags (flags),
    .req   (req),
    .res   (res)
  );

endmodule

// ===== sv/pmr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pmr_cfg_regs - configuration register file
// apb-style write/read access to base clock and vco limit registers
// ----------------------------------------------------------------------------
module pmr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [pmr_pkg::HZ_BITS-1:0]   pwdata,
  output logic [pmr_pkg::HZ_BITS-1:0]   prdata,
  output logic                          pready,
  output pmr_pkg::cfg_t                 cfg
);
  import pmr_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_clock_hz <= RESET_BASE_CLOCK;
      cfg.vco_low_hz    <= RESET_VCO_LOW;
      cfg.vco_high_hz   <= RESET_VCO_HIGH;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE_CLOCK: cfg.base_clock_hz <= pwdata;
        REG_VCO_LOW:    cfg.vco_low_hz    <= pwdata;
        REG_VCO_HIGH:   cfg.vco_high_hz   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE_CLOCK: prdata = cfg.base_clock_hz;
      REG_VCO_LOW:    prdata = cfg.vco_low_hz;
      REG_VCO_HIGH:   prdata = cfg.vco_high_hz;
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== sv/pmr_sequencer.sv =====
// ----------------------------------------------------------------------------
// pmr_sequencer - microcode sequencer
// step counter over the control store with conditional jumps on datapath flags
// ----------------------------------------------------------------------------
module pmr_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  pmr_pkg::flags_t flags,
  output pmr_pkg::ucode_t ctl
);
  import pmr_pkg::*;

  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] pc_next;
  logic               take;

  assign ctl = ucode_rom(pc);

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:       take = 1'b0;
      C_NO_REQ:      take = !flags.req_fire;
      C_GCD_BUSY:    take = flags.gcd_busy;
      C_G_ZERO:      take = flags.g_zero;
      C_DIV_BUSY:    take = flags.div_busy;
      C_OUT_BLOCKED: take = flags.out_blocked;
      C_ALWAYS:      take = 1'b1;
      default:       take = 1'b1;
    endcase
    pc_next = take ? ctl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== sv/pmr_datapath.sv =====
// ----------------------------------------------------------------------------
// pmr_datapath - ratio solver datapath
// mhz conversion, binary gcd, two-lane restoring divider and result register
// ----------------------------------------------------------------------------
module pmr_datapath #(
  parameter int DIVIDER_BITS    = pmr_pkg::DEFAULT_DIVIDER_BITS,
  parameter int MULTIPLIER_BITS = pmr_pkg::DEFAULT_MULTIPLIER_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  pmr_pkg::ucode_t ctl,
  input  pmr_pkg::cfg_t   cfg,
  output pmr_pkg::flags_t flags,
  pmr_req_if.sink         req,
  pmr_res_if.source       res
);
  import pmr_pkg::*;

  localparam int WORD_BITS = DATA_BITS + MULTIPLIER_BITS;

  // captured request
  logic [HZ_BITS-1:0]   ref_hz;
  logic [HZ_BITS-1:0]   tgt_hz;
  logic                 vco_bad;
  // mhz values, gcd working set, divider lanes
  logic [DATA_BITS-1:0] rm, tm;
  logic [DATA_BITS-1:0] a, b, g;
  logic [CNT_BITS-1:0]  k;
  logic [DATA_BITS-1:0] rem_n, rem_m, qn, qm;
  logic [CNT_BITS-1:0]  cnt;
  logic                 out_valid;

  logic                 req_fire;
  logic [HZ_BITS-1:0]   mul_x;
  logic [PROD_BITS-1:0] prod;
  logic [DATA_BITS-1:0] q_est;
  logic [HZ_BITS-1:0]   corr_x;
  logic [DATA_BITS-1:0] corr_q;
  logic [HZ_BITS-1:0]   back;
  logic [HZ_BITS-1:0]   resid;
  logic [DATA_BITS-1:0] q_fixed;
  logic [DATA_BITS-1:0] a_next, b_next;
  logic [CNT_BITS-1:0]  k_next;
  logic [DATA_BITS:0]   sh_n, sh_m;
  logic                 bit_n, bit_m;
  logic [DATA_BITS-1:0] rem_n_next, rem_m_next;
  logic [1:0]           status_next;
  logic [DATA_BITS-1:0] n_final, m_final;
  logic [WORD_BITS-1:0] wide_word;
  logic [CW_BITS-1:0]   word_next;
  logic                 finish_go;

  assign req.ready = (ctl.op == OP_IDLE) && !rst;
  assign req_fire  = req.valid && req.ready;

  assign flags.req_fire    = req_fire;
  assign flags.gcd_busy    = (a != '0) && (b != '0);
  assign flags.g_zero      = (g == '0);
  assign flags.div_busy    = (cnt != CNT_BITS'(1));
  assign flags.out_blocked = out_valid && !res.ready;

  assign finish_go = (ctl.op == OP_FINISH) && !flags.out_blocked;

  // hz to mhz: reciprocal estimate, then a one-step correction
  always_comb begin
    mul_x   = (ctl.op == OP_MUL_TGT) ? tgt_hz : ref_hz;
    prod    = PROD_BITS'(mul_x) * PROD_BITS'(RECIP);
    q_est   = prod[RECIP_SHIFT +: DATA_BITS];
    corr_x  = (ctl.op == OP_CORR_TGT) ? tgt_hz : ref_hz;
    corr_q  = (ctl.op == OP_CORR_TGT) ? tm : rm;
    back    = HZ_BITS'(HZ_BITS'(corr_q) * HZ_PER_MHZ);
    resid   = corr_x - back;
    q_fixed = corr_q + DATA_BITS'(resid >= HZ_PER_MHZ);
  end

  // one binary gcd step; odd-odd pairs subtract and halve in one go
  always_comb begin
    a_next = a;
    b_next = b;
    k_next = k;
    if (!a[0] && !b[0]) begin
      a_next = a >> 1;
      b_next = b >> 1;
      k_next = k + 1'b1;
    end else if (!a[0]) begin
      a_next = a >> 1;
    end else if (!b[0]) begin
      b_next = b >> 1;
    end else if (a >= b) begin
      a_next = (a - b) >> 1;
    end else begin
      b_next = (b - a) >> 1;
    end
  end

  // restoring divider, one quotient bit per lane per step
  always_comb begin
    sh_n       = {rem_n, qn[DATA_BITS-1]};
    sh_m       = {rem_m, qm[DATA_BITS-1]};
    bit_n      = (sh_n >= {1'b0, g});
    bit_m      = (sh_m >= {1'b0, g});
    rem_n_next = bit_n ? DATA_BITS'(sh_n - {1'b0, g}) : sh_n[DATA_BITS-1:0];
    rem_m_next = bit_m ? DATA_BITS'(sh_m - {1'b0, g}) : sh_m[DATA_BITS-1:0];
  end

  // result assembly
  always_comb begin
    if (g == '0) begin
      status_next = STATUS_NO_RATIO;
      n_final     = '0;
      m_final     = '0;
    end else begin
      n_final = qn;
      m_final = qm;
      if ((qn >> DIVIDER_BITS) != '0) begin
        status_next = STATUS_N_BIG;
      end else if ((qm >> MULTIPLIER_BITS) != '0) begin
        status_next = STATUS_M_BIG;
      end else begin
        status_next = STATUS_OK;
      end
    end
    wide_word = (WORD_BITS'(n_final) << MULTIPLIER_BITS) | WORD_BITS'(m_final);
    word_next = (status_next == STATUS_OK) ? wide_word[CW_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_IDLE: begin
        if (req_fire) begin
          ref_hz  <= (req.reference_hz == '0) ? cfg.base_clock_hz : req.reference_hz;
          tgt_hz  <= req.target_hz;
          vco_bad <= (req.target_hz > cfg.vco_high_hz) ||
                     (req.target_hz < cfg.vco_low_hz);
        end
      end
      OP_MUL_REF:  rm <= q_est;
      OP_CORR_REF: rm <= q_fixed;
      OP_MUL_TGT:  tm <= q_est;
      OP_CORR_TGT: tm <= q_fixed;
      OP_GCD_INIT: begin
        a <= rm;
        b <= tm;
        k <= '0;
      end
      OP_GCD_STEP: begin
        if (flags.gcd_busy) begin
          a <= a_next;
          b <= b_next;
          k <= k_next;
        end
      end
      OP_GCD_DONE: g <= DATA_BITS'((a | b) << k);
      OP_DIV_INIT: begin
        rem_n <= '0;
        rem_m <= '0;
        qn    <= rm;
        qm    <= tm;
        cnt   <= CNT_BITS'(DATA_BITS);
      end
      OP_DIV_STEP: begin
        rem_n <= rem_n_next;
        rem_m <= rem_m_next;
        qn    <= {qn[DATA_BITS-2:0], bit_n};
        qm    <= {qm[DATA_BITS-2:0], bit_m};
        cnt   <= cnt - 1'b1;
      end
      OP_FINISH: begin
        if (finish_go) begin
          res.status           <= status_next;
          res.divider_n        <= n_final;
          res.multiplier_m     <= m_final;
          res.control_word     <= word_next;
          res.vco_out_of_range <= vco_bad;
        end
      end
      default: ;
    endcase
  end

  assign res.valid = out_valid;

endmodule

// ===== verif/tb_pll_mn_ratio_solver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pll_mn_ratio_solver - self-checking bench for the pll m/n ratio solver
// drives frequency requests over valid/ready and programs the registers over
// apb; a scoreboard class predicts every result and checks it field by field
// ----------------------------------------------------------------------------
module tb_pll_mn_ratio_solver;
  import pmr_pkg::*;

  localparam int unsigned N_LIMIT = (1 << DEFAULT_DIVIDER_BITS) - 1;
  localparam int unsigned M_LIMIT = (1 << DEFAULT_MULTIPLIER_BITS) - 1;
  localparam int unsigned MAX_MHZ = 4294;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned DRAIN_CYCLES = 60;
  // index with no register behind it, writes must be dropped
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [1:0]           status;
    logic [DATA_BITS-1:0] divider_n;
    logic [DATA_BITS-1:0] multiplier_m;
    logic [CW_BITS-1:0]   control_word;
    logic                 vco_out_of_range;
  } ratio_result_t;

  // tracks the register copy, predicts each request and checks the results
  class ratio_scoreboard;
    logic [HZ_BITS-1:0] base_clock_hz;
    logic [HZ_BITS-1:0] vco_low_hz;
    logic [HZ_BITS-1:0] vco_high_hz;
    ratio_result_t      pending_ratios[$];
    int unsigned        failures;

    function new();
      base_clock_hz = RESET_BASE_CLOCK;
      vco_low_hz    = RESET_VCO_LOW;
      vco_high_hz   = RESET_VCO_HIGH;
      failures      = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [HZ_BITS-1:0] value);
      case (index)
        REG_BASE_CLOCK: base_clock_hz = value;
        REG_VCO_LOW:    vco_low_hz    = value;
        REG_VCO_HIGH:   vco_high_hz   = value;
        default: ;
      endcase
    endfunction

    function ratio_result_t solve_ratio(logic [HZ_BITS-1:0] ref_hz,
                                        logic [HZ_BITS-1:0] tgt_hz);
      ratio_result_t      r;
      logic [HZ_BITS-1:0] ref_mhz, tgt_mhz, a, b, rem, n, m;
      r = '0;
      // zero reference falls back to the base clock register
      ref_mhz = ((ref_hz == '0) ? base_clock_hz : ref_hz) / HZ_PER_MHZ;
      tgt_mhz = tgt_hz / HZ_PER_MHZ;
      a = ref_mhz;
      b = tgt_mhz;
      while (b != '0) begin
        rem = a % b;
        a = b;
        b = rem;
      end
      if (a == '0) begin
        r.status = STATUS_NO_RATIO;
      end else begin
        n = ref_mhz / a;
        m = tgt_mhz / a;
        r.divider_n    = n[DATA_BITS-1:0];
        r.multiplier_m = m[DATA_BITS-1:0];
        // divider check wins when both limits are exceeded
        if (n > N_LIMIT) r.status = STATUS_N_BIG;
        else if (m > M_LIMIT) r.status = STATUS_M_BIG;
        else r.status = STATUS_OK;
        if (r.status == STATUS_OK) begin
          r.control_word = CW_BITS'((n << DEFAULT_MULTIPLIER_BITS) | m);
        end
      end
      r.vco_out_of_range = (tgt_hz > vco_high_hz) || (tgt_hz < vco_low_hz);
      return r;
    endfunction

    function void note_request(logic [HZ_BITS-1:0] ref_hz,
                               logic [HZ_BITS-1:0] tgt_hz);
      pending_ratios.push_back(solve_ratio(ref_hz, tgt_hz));
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(ratio_result_t got);
      ratio_result_t want;
      if (pending_ratios.size() == 0) begin
        $error("result transaction with no request outstanding");
        failures++;
        return;
      end
      want = pending_ratios.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("divider_n", 16'(want.divider_n), 16'(got.divider_n));
      compare_field("multiplier_m", 16'(want.multiplier_m), 16'(got.multiplier_m));
      compare_field("control_word", 16'(want.control_word), 16'(got.control_word));
      compare_field("vco_out_of_range", 16'(want.vco_out_of_range),
                    16'(got.vco_out_of_range));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel, penable, pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [HZ_BITS-1:0]   pwdata, prdata;
  logic                 pready;

  // percent of cycles each side holds off; zeroed for the no-idle stretch
  int unsigned     stall_pct = 27;
  ratio_scoreboard sb = new();

  pmr_req_if req_ch();
  pmr_res_if res_ch();

  pll_mn_ratio_solver dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // whole MHz plus a random sub-MHz part, kept inside 32 bits
  function automatic logic [HZ_BITS-1:0] mhz_to_hz(int unsigned mhz);
    int unsigned frac_max;
    frac_max = (mhz >= MAX_MHZ) ? 967295 : 999999;
    return HZ_BITS'(mhz * 1000000 + $urandom_range(0, frac_max));
  endfunction

  // entered and left at a falling edge; valid stays up until the transaction
  task automatic send_request(input logic [HZ_BITS-1:0] ref_hz,
                              input logic [HZ_BITS-1:0] tgt_hz);
    while ($urandom_range(99) < stall_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.reference_hz <= ref_hz;
    req_ch.target_hz    <= tgt_hz;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(ref_hz, tgt_hz);
    @(negedge clk);
  endtask

  // apb write: setup then access phase, entered and left at a falling edge
  task automatic write_reg(input logic [1:0] index, input logic [HZ_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_register(index, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // every result back, then time for the sequencer to go idle
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (sb.pending_ratios.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly reducible ratios near the pll limits, plus fallback, vco edges,
  // sub-MHz values and raw noise
  task automatic random_requests(input int unsigned count);
    logic [HZ_BITS-1:0] ref_hz, tgt_hz;
    int unsigned        sel, n, m, g, hi;
    repeat (count) begin
      sel = $urandom_range(99);
      n   = $urandom_range(1, 34);
      m   = $urandom_range(0, 530);
      hi  = (n > m) ? n : m;
      g   = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_MHZ / hi)
                                     : $urandom_range(1, 8);
      ref_hz = mhz_to_hz(n * g);
      tgt_hz = mhz_to_hz(m * g);
      if (sel < 55) begin
        // well-formed ratio, already set above
      end else if (sel < 65) begin
        ref_hz = '0;
        tgt_hz = mhz_to_hz($urandom_range(0, 1500));
      end else if (sel < 73) begin
        // right on or just past a vco limit
        case ($urandom_range(3))
          0: tgt_hz = sb.vco_low_hz - 1;
          1: tgt_hz = sb.vco_low_hz;
          2: tgt_hz = sb.vco_high_hz;
          default: tgt_hz = sb.vco_high_hz + 1;
        endcase
      end else if (sel < 80) begin
        // below one MHz on one or both sides
        ref_hz = $urandom_range(0, 999999);
        tgt_hz = $urandom_range(0, 2999999);
      end else begin
        ref_hz = $urandom;
        tgt_hz = $urandom;
      end
      send_request(ref_hz, tgt_hz);
    end
  endtask

  // result side: ready changes at the falling edge
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result transactions are taken at the rising edge
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        sb.check_result('{status:           res_ch.status,
                          divider_n:        res_ch.divider_n,
                          multiplier_m:     res_ch.multiplier_m,
                          control_word:     res_ch.control_word,
                          vco_out_of_range: res_ch.vco_out_of_range});
      end
    end
  end

  initial begin
    logic [HZ_BITS-1:0] low_hz;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.reference_hz <= '0;
    req_ch.target_hz    <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners under the reset register values
    send_request(32'd0, 32'd0);                   // base clock, target zero MHz
    send_request(32'd500000, 32'd999999);         // both below a MHz
    send_request(32'd1, 32'd1);                   // tiny nonzero reference
    send_request(32'd999999, 32'd1000000000);     // reference zero MHz only
    send_request(32'd24000000, 32'd1200000000);
    send_request(32'd25000000, 32'd1000000000);
    send_request(32'd31000000, 32'd511000000);    // largest legal n and m
    send_request(32'd32000000, 32'd1000000);      // divider too big
    send_request(32'd1000000, 32'd512000000);     // multiplier too big
    send_request(32'd17000000, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'd4293000000);  // both limits exceeded
    send_request(32'h8000_0000, 32'h7FFF_FFFF);
    send_request(32'd1000000, 32'd699999999);     // vco edges
    send_request(32'd1000000, 32'd700000000);
    send_request(32'd1000000, 32'd1300000000);
    send_request(32'd0, 32'd1300000001);
    send_request(32'd5000000, 32'd0);
    random_requests(ITEMS_PER_PHASE);

    // zero base clock and the widest vco window
    wait_idle();
    write_reg(REG_BASE_CLOCK, 32'd0);
    write_reg(REG_VCO_LOW, 32'd0);
    write_reg(REG_VCO_HIGH, 32'hFFFF_FFFF);
    send_request(32'd0, 32'd0);
    send_request(32'd0, 32'd500000000);
    random_requests(ITEMS_PER_PHASE);

    // largest base clock, inverted window, and no idling on either side
    wait_idle();
    write_reg(REG_BASE_CLOCK, 32'hFFFF_FFFF);
    write_reg(REG_VCO_LOW, 32'hFFFF_FFFF);
    write_reg(REG_VCO_HIGH, 32'd0);
    write_reg(REG_UNMAPPED, $urandom);
    stall_pct = 0;
    send_request(32'd0, 32'd858000000);
    random_requests(ITEMS_PER_PHASE);

    // random settings with a sensible window
    wait_idle();
    stall_pct = 27;
    low_hz = $urandom_range(100000000, 900000000);
    write_reg(REG_BASE_CLOCK, $urandom_range(1000000, 60000000));
    write_reg(REG_VCO_LOW, low_hz);
    write_reg(REG_VCO_HIGH, low_hz + $urandom_range(0, 1500000000));
    random_requests(ITEMS_PER_PHASE);

    wait_idle();
    write_reg(REG_BASE_CLOCK, 32'd25000000);
    write_reg(REG_VCO_LOW, 32'd600000000);
    write_reg(REG_VCO_HIGH, 32'd1200000000);
    random_requests(ITEMS_PER_PHASE);

    // drain, then leave room for any stray result
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending_ratios.size() == 0) begin
      $display("PASS pll_mn_ratio_solver");
    end else begin
      $display("FAIL pll_mn_ratio_solver");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("FAIL pll_mn_ratio_solver");
    $finish;
  end

endmodule
